/* sv/conv3_pkg.sv */
// Shared types and constants for the 3x3 convolution stream core.
// Used by every module of the block but conv3_ram; depends on nothing.
package conv3_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;
    localparam int KERNEL_TAPS = 3;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int KROW_W      = KERNEL_TAPS * COEF_W;
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    localparam int PART_W      = PROD_W + 2;
    localparam int SUM_W       = 28;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int COLS_REG_W  = 10;
    localparam int ROWS_REG_W  = 9;
    localparam int COLS_RESET  = 320;
    localparam int ROWS_RESET  = 253;

    typedef enum logic [2:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MID    = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_IMAGE_COLUMNS = 3'd3,
        REG_IMAGE_ROWS    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [KERNEL_TAPS-1:0][KROW_W-1:0] kernel;
        logic [COL_W-1:0]                   col_last;
        logic [ROW_W-1:0]                   row_last;
        logic                               restart;
    } cfg_t;

    typedef struct packed {
        logic [KERNEL_TAPS-1:0][KERNEL_TAPS-1:0][PIX_W-1:0] win;
        logic                                               row_end;
        logic                                               frame_end;
    } win_item_t;

endpackage

/* sv/conv3_ram.sv */
// Generic simple dual-port RAM with registered read.
// Standalone; used for the line stores.
module conv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/conv3_front.sv */
// Front end: pixel intake, position counters, line stores and 3x3 window.
// Depends on conv3_pkg and conv3_ram; pushes window items into the queue.
module conv3_front
    import conv3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic             room,
    output logic             push,
    output win_item_t        push_item
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             accept;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_produce_reg;
    logic             s1_rend_reg;
    logic             s1_fend_reg;

    logic [PIX_W-1:0] up_rd, mid_rd;
    logic [KERNEL_TAPS-1:0][KERNEL_TAPS-1:0][PIX_W-1:0] win_reg, win_next;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == cfg.col_last)
            begin
                col_next = '0;
                row_next = (row_reg == cfg.row_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= s_pixel;
            s1_col_reg     <= col_reg;
            s1_produce_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_rend_reg    <= (col_reg == cfg.col_last);
            s1_fend_reg    <= (col_reg == cfg.col_last) && (row_reg == cfg.row_last);
        end
    end

    conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_line_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_line_middle (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    always_comb
    begin
        for (int m = 0; m < KERNEL_TAPS; m++)
        begin
            win_next[m][0] = win_reg[m][1];
            win_next[m][1] = win_reg[m][2];
        end
        win_next[0][2] = up_rd;
        win_next[1][2] = mid_rd;
        win_next[2][2] = s1_px_reg;
    end

    assign push                = s1_valid_reg && s1_produce_reg;
    assign push_item.win       = win_next;
    assign push_item.row_end   = s1_rend_reg;
    assign push_item.frame_end = s1_fend_reg;

`ifndef SYNTH
    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!push_item.frame_end || push_item.row_end))
        else $error("frame end without row end");
    a_accept_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel lost before line store stage");
`endif

endmodule

/* sv/conv3_fifo.sv */
// Short queue of window items between the front end and the MAC back end.
// Depends on conv3_pkg.
module conv3_fifo
    import conv3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  win_item_t push_item,
    input  logic      pop,
    output win_item_t pop_item,
    output logic      empty,
    output logic      room
);

    win_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               full;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign room     = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

/* sv/conv3_back.sv */
// Back end: nine products, partial sums, final sum and output register.
// Depends on conv3_pkg; drains the item queue under output back-pressure.
module conv3_back
    import conv3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             empty,
    input  win_item_t        pop_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] out_sum,
    output logic             out_row_end,
    output logic             out_frame_end
);

    logic              en;
    logic              p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic              p1_rend_reg, p1_fend_reg;
    logic              p2_rend_reg, p2_fend_reg;
    logic              out_rend_reg, out_fend_reg;
    logic [PROD_W-1:0] prod_reg  [KERNEL_TAPS][KERNEL_TAPS];
    logic [PROD_W-1:0] prod_next [KERNEL_TAPS][KERNEL_TAPS];
    logic [PART_W-1:0] part_reg  [KERNEL_TAPS];
    logic [PART_W-1:0] part_next [KERNEL_TAPS];
    logic [SUM_W-1:0]  sum_reg, sum_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = !empty && en;

    always_comb
    begin
        for (int m = 0; m < KERNEL_TAPS; m++)
        begin
            for (int n = 0; n < KERNEL_TAPS; n++)
            begin
                prod_next[m][n] = $signed({{(PROD_W-PIX_W){1'b0}}, pop_item.win[m][n]})
                                * $signed({{(PROD_W-COEF_W){cfg.kernel[m][n*COEF_W+COEF_W-1]}},
                                           cfg.kernel[m][n*COEF_W +: COEF_W]});
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < KERNEL_TAPS; m++)
        begin
            part_next[m] = {{2{prod_reg[m][0][PROD_W-1]}}, prod_reg[m][0]}
                         + {{2{prod_reg[m][1][PROD_W-1]}}, prod_reg[m][1]}
                         + {{2{prod_reg[m][2][PROD_W-1]}}, prod_reg[m][2]};
        end
        sum_next = {part_reg[0][PART_W-1], part_reg[0]}
                 + {part_reg[1][PART_W-1], part_reg[1]}
                 + {part_reg[2][PART_W-1], part_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= pop;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_next;
            p1_rend_reg  <= pop_item.row_end;
            p1_fend_reg  <= pop_item.frame_end;
            part_reg     <= part_next;
            p2_rend_reg  <= p1_rend_reg;
            p2_fend_reg  <= p1_fend_reg;
            sum_reg      <= sum_next;
            out_rend_reg <= p2_rend_reg;
            out_fend_reg <= p2_fend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_sum       = sum_reg;
    assign out_row_end   = out_rend_reg;
    assign out_frame_end = out_fend_reg;

`ifndef SYNTH
    a_pop_reaches_p1: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> p1_valid_reg)
        else $error("popped item did not enter product stage");
`endif

endmodule

/* sv/conv3x3_valid_stream_core.sv */
// 3x3 valid-region image convolution over a raster pixel stream.
// Holds the APB register file and joins conv3_front, conv3_fifo and conv3_back.
// Depends on conv3_pkg.
//
// Usage:
//   Pixels enter on the s_ channel (s_tdata[7:0] = pixel), one per clock while
//   s_tready is high. For each pixel at row >= 2 and column >= 2 one result
//   leaves on the m_ channel: m_tdata[27:0] = signed correlation sum, m_tlast
//   = last result of an output row, m_tuser = last result of the frame. Other
//   pixels give no result. A pixel passes the line-store stage, the queue and
//   the product, partial-sum and output registers. Throughput is one item per
//   cycle while m_tready is high, set by the single line store read port per
//   pixel. Kernel rows and image size are written over APB (64-bit data,
//   register i at byte address 8*i); the user must write them only while the
//   block is idle, which the block does not enforce; a size write restarts the
//   frame. Out-of-range sizes are clamped to 3..512 columns, 3..256 rows. Reset
//   clears kernels, sets 320x253, zeroes positions and window and empties the
//   pipeline; line stores need no clearing. When the receiver stalls, the
//   output register holds its item, the back end stops, and the four-entry
//   queue keeps taking items until nearly full, after which s_tready drops.
module conv3x3_valid_stream_core
    import conv3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [27:0] conv_sum, [31:28] zero
    output logic        m_tlast,
    output logic        m_tuser,   // [0] frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [KERNEL_TAPS-1:0][KROW_W-1:0] kernel_reg;
    logic [COLS_REG_W-1:0]              cols_reg;
    logic [ROWS_REG_W-1:0]              rows_reg;
    logic                               restart;
    logic                               wr_en;
    reg_idx_t                           idx;
    cfg_t                               cfg;

    logic       room, push, pop, empty;
    win_item_t  push_item, pop_item;
    logic [SUM_W-1:0] out_sum;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign idx     = reg_idx_t'(paddr[5:3]);
    assign restart = wr_en && ((idx == REG_IMAGE_COLUMNS) || (idx == REG_IMAGE_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= '0;
            cols_reg   <= COLS_REG_W'(COLS_RESET);
            rows_reg   <= ROWS_REG_W'(ROWS_RESET);
        end
        else
        begin
            if (wr_en)
            begin
                unique case (idx)
                    REG_KERNEL_TOP:    kernel_reg[0] <= pwdata[KROW_W-1:0];
                    REG_KERNEL_MID:    kernel_reg[1] <= pwdata[KROW_W-1:0];
                    REG_KERNEL_BOTTOM: kernel_reg[2] <= pwdata[KROW_W-1:0];
                    REG_IMAGE_COLUMNS:
                    begin
                        cols_reg <= pwdata[COLS_REG_W-1:0];
                    end
                    REG_IMAGE_ROWS:
                    begin
                        rows_reg <= pwdata[ROWS_REG_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_KERNEL_TOP:    prdata = 64'(kernel_reg[0]);
            REG_KERNEL_MID:    prdata = 64'(kernel_reg[1]);
            REG_KERNEL_BOTTOM: prdata = 64'(kernel_reg[2]);
            REG_IMAGE_COLUMNS: prdata = 64'(cols_reg);
            REG_IMAGE_ROWS:    prdata = 64'(rows_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.kernel  = kernel_reg;
        cfg.restart = restart;
        priority if (cols_reg < COLS_REG_W'(3))
        begin
            cfg.col_last = COL_W'(2);
        end
        else if (cols_reg > COLS_REG_W'(MAX_COLUMNS))
        begin
            cfg.col_last = COL_W'(MAX_COLUMNS - 1);
        end
        else
        begin
            cfg.col_last = COL_W'(cols_reg - 1'b1);
        end
        priority if (rows_reg < ROWS_REG_W'(3))
        begin
            cfg.row_last = ROW_W'(2);
        end
        else if (rows_reg > ROWS_REG_W'(MAX_ROWS))
        begin
            cfg.row_last = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            cfg.row_last = ROW_W'(rows_reg - 1'b1);
        end
    end

    conv3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata),
        .room      (room),
        .push      (push),
        .push_item (push_item)
    );

    conv3_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty),
        .room      (room)
    );

    conv3_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .empty         (empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_sum       (out_sum),
        .out_row_end   (m_tlast),
        .out_frame_end (m_tuser)
    );

    assign m_tdata = {4'b0000, out_sum};

endmodule
